// ===== rtl/njs_pkg.sv =====
// shared types, constants and pick rule for the nonpreemptive job scheduler
package njs_pkg;

  // table geometry
  localparam int MAX_JOBS = 64;
  localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);

  // field widths
  localparam int TIME_W  = 24;
  localparam int ID_W    = 16;
  localparam int ARR_W   = 20;
  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int KEY_W   = 20;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // command codes
  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_NEXT  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_LOADED = 2'd0,
    STAT_RUN    = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_NONE   = 2'd3
  } status_e;

  // pick rules
  typedef enum logic [1:0] {
    POL_FCFS = 2'd0,
    POL_SJF  = 2'd1,
    POL_PRIO = 2'd2
  } policy_e;

  // one stored job, id in the low bits
  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
    logic [ARR_W-1:0]   arr;
    logic [ID_W-1:0]    id;
  } job_t;

  // one run result, run id in the low bits
  typedef struct packed {
    logic              all_done;
    logic [TIME_W-1:0] busy_total;
    logic [TIME_W-1:0] waiting;
    logic [TIME_W-1:0] turnaround;
    logic              has_slice;
    logic [TIME_W-1:0] end_time;
    logic [TIME_W-1:0] start_time;
    logic [ID_W-1:0]   run_id;
  } res_t;

  localparam int IN_TDATA_W  = (($bits(job_t) + 7) / 8) * 8;
  localparam int OUT_TDATA_W = (($bits(res_t) + 7) / 8) * 8;

  // sort key of a job under the selected rule
  function automatic logic [KEY_W-1:0] pick_key(job_t j, logic [1:0] mode);
    logic [KEY_W-1:0] k;
    case (mode)
      POL_SJF:  k = KEY_W'(j.burst);
      POL_PRIO: k = KEY_W'(j.prio);
      default:  k = KEY_W'(j.arr);
    endcase
    return k;
  endfunction

  // true if job a wins over job b; full ties keep b
  function automatic logic beats(job_t a, job_t b, logic [1:0] mode);
    logic [KEY_W-1:0] ka;
    logic [KEY_W-1:0] kb;
    logic             w;
    ka = pick_key(a, mode);
    kb = pick_key(b, mode);
    if (ka != kb) begin
      w = (ka < kb);
    end else if (a.id != b.id) begin
      w = (a.id < b.id);
    end else begin
      w = (a.arr < b.arr);
    end
    return w;
  endfunction

endpackage

// ===== rtl/nonpreemptive_job_scheduler.sv =====
// nonpreemptive job scheduler: job table, two-pass scan sequencer and shared adder
//
// Commands arrive on the slave stream (func in tuser). A load or a clear has its
// result in the output register in the cycle after it is accepted. A next-run request
// scans the job table twice, one slot per cycle through the table's single
// registered read port: the first pass finds whether any pending job has arrived
// and the earliest pending arrival, the second pass picks the winner. Four more
// steps on one shared 24-bit add/subtract unit give end time, busy total,
// turnaround and waiting, and one step issues the result. The input is not ready while
// a next-run request is being served. A result that waits in the output register
// holds off the next command until it is taken.
module nonpreemptive_job_scheduler
  import njs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write: policy_mode
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_data_i,
  // command stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: job_id, arrival_time, burst_length, priority_level
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: func
  input  logic [1:0]             s_axis_tuser,
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: run_id, start_time, end_time, has_slice, turnaround, waiting,
  //        busy_total, all_done
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: status
  output logic [1:0]             m_axis_tuser
);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN_A = 3'd1;
  localparam logic [2:0] S_SCAN_B = 3'd2;
  localparam logic [2:0] S_END    = 3'd3;
  localparam logic [2:0] S_BUSY   = 3'd4;
  localparam logic [2:0] S_TURN   = 3'd5;
  localparam logic [2:0] S_WAIT   = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  // job table
  job_t              mem_q [MAX_JOBS];
  job_t              rdata_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  job_t              in_job;

  // control state
  logic [2:0]          state_q, state_d;
  logic [1:0]          policy_q, policy_d;
  logic [MAX_JOBS-1:0] fin_q, fin_d;
  logic [CNT_W-1:0]    ent_cnt_q, ent_cnt_d;
  logic [CNT_W-1:0]    fin_cnt_q, fin_cnt_d;
  logic [TIME_W-1:0]   cur_time_q, cur_time_d;
  logic [TIME_W-1:0]   busy_q, busy_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic                rd_vld_q, rd_vld_d;
  logic                rd_fin_q;
  logic [IDX_W-1:0]    rd_slot_q;
  logic                ready_q, ready_d;
  logic                have_min_q, have_min_d;
  logic                have_best_q, have_best_d;
  logic                m_valid_q, m_valid_d;

  // scan payload
  logic [TIME_W-1:0]  t_q, t_d;
  logic [ARR_W-1:0]   min_q, min_d;
  job_t               best_q, best_d;
  logic [IDX_W-1:0]   best_slot_q, best_slot_d;
  logic [TIME_W-1:0]  end_q, end_d;
  logic [TIME_W-1:0]  turn_q, turn_d;
  logic [TIME_W-1:0]  wait_q, wait_d;
  logic [1:0]         m_status_q, m_status_d;
  res_t               m_res_q, m_res_d;

  // shared add/subtract unit
  logic [TIME_W-1:0]  alu_a, alu_b;
  logic               alu_sub;
  logic [TIME_W:0]    alu_res;

  logic               out_free;
  logic               in_acc;
  logic               scanning;
  logic               scan_issue;
  logic               scan_done;
  logic [TIME_W-1:0]  rd_arr_ext;
  func_e              in_func;

  assign in_job     = job_t'(s_axis_tdata[$bits(job_t)-1:0]);
  assign in_func    = func_e'(s_axis_tuser);
  assign out_free   = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  assign scanning   = (state_q == S_SCAN_A) || (state_q == S_SCAN_B);
  assign scan_issue = scanning && (idx_q < ent_cnt_q);
  assign scan_done  = scanning && (idx_q == ent_cnt_q) && !rd_vld_q;
  assign rd_arr_ext = TIME_W'(rdata_q.arr);

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = OUT_TDATA_W'(m_res_q);

  // operand select for the shared unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      S_END: begin
        alu_a = t_q;
        alu_b = TIME_W'(best_q.burst);
      end
      S_BUSY: begin
        alu_a = busy_q;
        alu_b = TIME_W'(best_q.burst);
      end
      S_TURN: begin
        alu_a   = end_q;
        alu_b   = TIME_W'(best_q.arr);
        alu_sub = 1'b1;
      end
      S_WAIT: begin
        alu_a   = turn_q;
        alu_b   = TIME_W'(best_q.burst);
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
    alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
  end

  // sequencer and next-state logic
  always_comb begin
    state_d     = state_q;
    policy_d    = policy_q;
    fin_d       = fin_q;
    ent_cnt_d   = ent_cnt_q;
    fin_cnt_d   = fin_cnt_q;
    cur_time_d  = cur_time_q;
    busy_d      = busy_q;
    idx_d       = idx_q;
    rd_vld_d    = scan_issue;
    ready_d     = ready_q;
    have_min_d  = have_min_q;
    have_best_d = have_best_q;
    t_d         = t_q;
    min_d       = min_q;
    best_d      = best_q;
    best_slot_d = best_slot_q;
    end_d       = end_q;
    turn_d      = turn_q;
    wait_d      = wait_q;
    m_valid_d   = m_valid_q;
    m_status_d  = m_status_q;
    m_res_d     = m_res_q;
    mem_we      = 1'b0;
    mem_waddr   = ent_cnt_q[IDX_W-1:0];

    // output transaction taken
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    // register write
    if (cfg_valid_i && cfg_ready_o) begin
      policy_d = cfg_data_i;
    end

    if (scan_issue) begin
      idx_d = idx_q + 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          m_res_d = '0;
          case (in_func)
            FUNC_LOAD: begin
              m_valid_d = 1'b1;
              if (ent_cnt_q == CNT_W'(MAX_JOBS)) begin
                m_status_d = STAT_FULL;
              end else begin
                mem_we     = 1'b1;
                fin_d[ent_cnt_q[IDX_W-1:0]] = 1'b0;
                ent_cnt_d  = ent_cnt_q + 1'b1;
                m_status_d = STAT_LOADED;
              end
            end
            FUNC_CLEAR: begin
              m_valid_d  = 1'b1;
              fin_d      = '0;
              ent_cnt_d  = '0;
              fin_cnt_d  = '0;
              cur_time_d = '0;
              busy_d     = '0;
              m_status_d = STAT_LOADED;
            end
            FUNC_NEXT: begin
              if (fin_cnt_q >= ent_cnt_q) begin
                m_valid_d  = 1'b1;
                m_status_d = STAT_NONE;
              end else begin
                state_d     = S_SCAN_A;
                idx_d       = '0;
                t_d         = cur_time_q;
                ready_d     = 1'b0;
                have_min_d  = 1'b0;
                have_best_d = 1'b0;
              end
            end
            default: begin
              m_valid_d  = 1'b1;
              m_status_d = STAT_NONE;
            end
          endcase
        end
      end
      S_SCAN_A: begin
        // readiness and earliest pending arrival
        if (rd_vld_q && !rd_fin_q) begin
          if (rd_arr_ext <= t_q) begin
            ready_d = 1'b1;
          end
          if (!have_min_q || (rdata_q.arr < min_q)) begin
            min_d      = rdata_q.arr;
            have_min_d = 1'b1;
          end
        end
        if (scan_done) begin
          state_d = S_SCAN_B;
          idx_d   = '0;
          if (!ready_q) begin
            t_d = TIME_W'(min_q);
          end
        end
      end
      S_SCAN_B: begin
        // best arrived pending job
        if (rd_vld_q && !rd_fin_q && (rd_arr_ext <= t_q)) begin
          if (!have_best_q || beats(rdata_q, best_q, policy_q)) begin
            best_d      = rdata_q;
            best_slot_d = rd_slot_q;
            have_best_d = 1'b1;
          end
        end
        if (scan_done) begin
          state_d = S_END;
        end
      end
      S_END: begin
        end_d   = alu_res[TIME_W] ? TIME_MAX : alu_res[TIME_W-1:0];
        state_d = S_BUSY;
      end
      S_BUSY: begin
        busy_d  = alu_res[TIME_W] ? TIME_MAX : alu_res[TIME_W-1:0];
        state_d = S_TURN;
      end
      S_TURN: begin
        turn_d  = alu_res[TIME_W-1:0];
        state_d = S_WAIT;
      end
      S_WAIT: begin
        wait_d  = alu_res[TIME_W] ? '0 : alu_res[TIME_W-1:0];
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          m_valid_d          = 1'b1;
          m_status_d         = STAT_RUN;
          m_res_d.run_id     = best_q.id;
          m_res_d.start_time = t_q;
          m_res_d.end_time   = end_q;
          m_res_d.has_slice  = (best_q.burst != '0);
          m_res_d.turnaround = turn_q;
          m_res_d.waiting    = wait_q;
          m_res_d.busy_total = busy_q;
          m_res_d.all_done   = (CNT_W'(fin_cnt_q + 1'b1) == ent_cnt_q);
          fin_d[best_slot_q] = 1'b1;
          fin_cnt_d          = fin_cnt_q + 1'b1;
          cur_time_d         = end_q;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      policy_q    <= POL_FCFS;
      fin_q       <= '0;
      ent_cnt_q   <= '0;
      fin_cnt_q   <= '0;
      cur_time_q  <= '0;
      busy_q      <= '0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      ready_q     <= 1'b0;
      have_min_q  <= 1'b0;
      have_best_q <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      policy_q    <= policy_d;
      fin_q       <= fin_d;
      ent_cnt_q   <= ent_cnt_d;
      fin_cnt_q   <= fin_cnt_d;
      cur_time_q  <= cur_time_d;
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      rd_vld_q    <= rd_vld_d;
      ready_q     <= ready_d;
      have_min_q  <= have_min_d;
      have_best_q <= have_best_d;
      m_valid_q   <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    t_q         <= t_d;
    min_q       <= min_d;
    best_q      <= best_d;
    best_slot_q <= best_slot_d;
    end_q       <= end_d;
    turn_q      <= turn_d;
    wait_q      <= wait_d;
    m_status_q  <= m_status_d;
    m_res_q     <= m_res_d;
    rd_fin_q    <= fin_q[idx_q[IDX_W-1:0]];
    rd_slot_q   <= idx_q[IDX_W-1:0];
  end

  // job table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= in_job;
    end
    rdata_q <= mem_q[idx_q[IDX_W-1:0]];
  end

`ifndef SYNTH
  // never more finished jobs than loaded ones
  a_fin_le_ent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_cnt_q <= ent_cnt_q)
    else $error("finished count exceeds entry count");

  // a scan only runs while some job is pending
  a_busy_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (fin_cnt_q < ent_cnt_q))
    else $error("sequencer busy with nothing pending");

  // the second pass always finds a winner
  a_best_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_END) |-> have_best_q)
    else $error("no job picked after scan");

  // first pass always sees a pending arrival
  a_min_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN_B) && $past(state_q == S_SCAN_A) |-> have_min_q)
    else $error("no pending arrival found");

  // waiting never exceeds turnaround in an issued run
  a_wait_le_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && (m_status_q == STAT_RUN) |-> (m_res_q.waiting <= m_res_q.turnaround))
    else $error("waiting exceeds turnaround");
`endif

endmodule

// ===== test/tb_nonpreemptive_job_scheduler.sv =====
// testbench for the nonpreemptive job scheduler: predicted command results checked on the result stream
module tb_nonpreemptive_job_scheduler;
  import njs_pkg::*;

  // codes the package leaves unnamed
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam logic [1:0] POL_SPARE  = 2'd3;

  // job field ranges for random loads
  localparam int FIELDS_FULL   = 0;
  localparam int FIELDS_NARROW = 1;
  localparam int FIELDS_MID    = 2;

  localparam int RANDOM_ITEMS   = 1900;
  localparam int STALL_LIMIT    = 3000;
  localparam int TAIL_CYCLES    = 160;
  localparam int HOLDOFF_CYCLES = 400;

  // receiver stall patterns
  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_pattern_e;

  // one expected transaction on the result stream
  typedef struct packed {
    status_e status;
    res_t    res;
  } outcome_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [1:0]             cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // tdata: job_id, arrival_time, burst_length, priority_level
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  // tuser: func
  logic [1:0]             s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // tdata: run_id, start_time, end_time, has_slice, turnaround, waiting,
  //        busy_total, all_done
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // tuser: status
  logic [1:0]             m_axis_tuser;

  nonpreemptive_job_scheduler u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // scheduler state as the testbench sees it
  job_t              jobs_tbl [MAX_JOBS];
  bit                jobs_done [MAX_JOBS];
  int unsigned       jobs_loaded = 0;
  int unsigned       jobs_run    = 0;
  logic [TIME_W-1:0] clock_now   = '0;
  logic [TIME_W-1:0] busy_acc    = '0;
  logic [1:0]        pick_rule   = POL_FCFS;

  outcome_t outcome_q [$];
  int       fail_count  = 0;
  int       items_sent  = 0;
  int       holdoff_len = 0;
  bit       gaps_on     = 1'b1;
  int       burst_left  = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // expected result of one command, updating the tracked state
  function automatic outcome_t dispatch_outcome(logic [1:0] func, job_t j);
    outcome_t          o;
    int unsigned       t;
    int unsigned       lo;
    int unsigned       sum;
    int unsigned       turn;
    int unsigned       span;
    bit                ready;
    bit                seen;
    int                win;
    logic [KEY_W-1:0]  key;
    logic [55:0]       rank;
    logic [55:0]       best_rank;
    logic [TIME_W-1:0] fin;
    o = '0;
    case (func)
      FUNC_LOAD: begin
        if (jobs_loaded >= MAX_JOBS) begin
          o.status = STAT_FULL;
        end else begin
          jobs_tbl[jobs_loaded]  = j;
          jobs_done[jobs_loaded] = 1'b0;
          jobs_loaded++;
          o.status = STAT_LOADED;
        end
      end
      FUNC_CLEAR: begin
        foreach (jobs_done[k]) jobs_done[k] = 1'b0;
        jobs_loaded = 0;
        jobs_run    = 0;
        clock_now   = '0;
        busy_acc    = '0;
        o.status    = STAT_LOADED;
      end
      FUNC_NEXT: begin
        if (jobs_run >= jobs_loaded) begin
          o.status = STAT_NONE;
        end else begin
          // anything arrived yet, and the earliest pending arrival
          t     = clock_now;
          ready = 1'b0;
          seen  = 1'b0;
          lo    = 0;
          for (int k = 0; k < jobs_loaded; k++) begin
            if (!jobs_done[k]) begin
              if (jobs_tbl[k].arr <= t) ready = 1'b1;
              if (!seen || jobs_tbl[k].arr < lo) begin
                lo   = jobs_tbl[k].arr;
                seen = 1'b1;
              end
            end
          end
          if (!ready) t = lo;
          // winner: smallest key, then id, then arrival; first slot on full ties
          win       = -1;
          best_rank = '0;
          for (int k = 0; k < jobs_loaded; k++) begin
            if (!jobs_done[k] && jobs_tbl[k].arr <= t) begin
              case (pick_rule)
                POL_SJF:  key = KEY_W'(jobs_tbl[k].burst);
                POL_PRIO: key = KEY_W'(jobs_tbl[k].prio);
                default:  key = KEY_W'(jobs_tbl[k].arr);
              endcase
              rank = {key, jobs_tbl[k].id, jobs_tbl[k].arr};
              if (win < 0 || rank < best_rank) begin
                win       = k;
                best_rank = rank;
              end
            end
          end
          span = jobs_tbl[win].burst;
          sum  = t + span;
          fin  = (sum > TIME_MAX) ? TIME_MAX : TIME_W'(sum);
          sum  = busy_acc + span;
          busy_acc      = (sum > TIME_MAX) ? TIME_MAX : TIME_W'(sum);
          clock_now     = fin;
          jobs_done[win] = 1'b1;
          jobs_run++;
          turn = fin - jobs_tbl[win].arr;
          o.status         = STAT_RUN;
          o.res.run_id     = jobs_tbl[win].id;
          o.res.start_time = TIME_W'(t);
          o.res.end_time   = fin;
          o.res.has_slice  = (span != 0);
          o.res.turnaround = TIME_W'(turn);
          o.res.waiting    = (turn >= span) ? TIME_W'(turn - span) : '0;
          o.res.busy_total = busy_acc;
          o.res.all_done   = (jobs_run == jobs_loaded);
        end
      end
      default: begin
        o.status = STAT_NONE;
      end
    endcase
    return o;
  endfunction

  function automatic job_t mk_job(int id, int arr, int burst, int prio);
    job_t j;
    j.id    = ID_W'(id);
    j.arr   = ARR_W'(arr);
    j.burst = BURST_W'(burst);
    j.prio  = PRIO_W'(prio);
    return j;
  endfunction

  function automatic job_t random_job(int style);
    job_t j;
    case (style)
      FIELDS_NARROW: begin
        j = mk_job($urandom_range(0, 7), $urandom_range(0, 40), $urandom_range(0, 6),
                   $urandom_range(0, 3));
      end
      FIELDS_MID: begin
        j = mk_job($urandom, $urandom_range(0, 2000), $urandom_range(0, 300),
                   $urandom_range(0, 15));
      end
      default: begin
        j = mk_job($urandom, $urandom, $urandom, $urandom);
      end
    endcase
    return j;
  endfunction

  // one command transaction, with bursts and gaps on the sender side
  task automatic send_cmd(input logic [1:0] func, input job_t j);
    logic [IN_TDATA_W-1:0] word;
    int                    gap;
    word = '0;
    word[$bits(job_t)-1:0] = j;
    if (gaps_on && burst_left == 0) begin
      gap        = $urandom_range(1, 12);
      burst_left = $urandom_range(1, 16);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    outcome_q.push_back(dispatch_outcome(func, j));
    if (func != FUNC_SPARE) items_sent++;
  endtask

  // stop sending and wait for every expected result
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // policy write while the block is idle
  task automatic set_policy(input logic [1:0] mode);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    pick_rule = mode;
  endtask

  // empty table, unused command, extremes, zero burst, time jumps, duplicate ids
  task automatic test_directed();
    send_cmd(FUNC_NEXT, random_job(FIELDS_FULL));
    send_cmd(FUNC_SPARE, random_job(FIELDS_FULL));
    send_cmd(FUNC_CLEAR, random_job(FIELDS_FULL));
    send_cmd(FUNC_LOAD, mk_job(16'hFFFF, 20'hFFFFF, 16'hFFFF, 8'hFF));
    send_cmd(FUNC_LOAD, mk_job(0, 0, 0, 0));
    send_cmd(FUNC_LOAD, mk_job(5, 10, 3, 7));
    send_cmd(FUNC_LOAD, mk_job(5, 2, 3, 7));
    repeat (5) send_cmd(FUNC_NEXT, random_job(FIELDS_FULL));
    send_cmd(FUNC_CLEAR, random_job(FIELDS_FULL));
  endtask

  // equal keys fall back to id, then to arrival
  task automatic test_tie_rules();
    set_policy(POL_SJF);
    send_cmd(FUNC_LOAD, mk_job(9, 0, 4, 1));
    send_cmd(FUNC_LOAD, mk_job(3, 1, 4, 9));
    send_cmd(FUNC_LOAD, mk_job(3, 0, 4, 9));
    send_cmd(FUNC_LOAD, mk_job(1, 0, 20, 0));
    repeat (4) send_cmd(FUNC_NEXT, random_job(FIELDS_FULL));
    set_policy(POL_PRIO);
    send_cmd(FUNC_LOAD, mk_job(8, 6, 2, 4));
    send_cmd(FUNC_LOAD, mk_job(2, 3, 5, 4));
    send_cmd(FUNC_LOAD, mk_job(2, 1, 5, 4));
    repeat (3) send_cmd(FUNC_NEXT, random_job(FIELDS_FULL));
  endtask

  // long receiver hold-off while the table fills past full
  task automatic test_backpressure();
    set_policy(POL_SPARE);
    gaps_on     = 1'b0;
    holdoff_len = HOLDOFF_CYCLES;
    send_cmd(FUNC_CLEAR, random_job(FIELDS_FULL));
    for (int k = 0; k < MAX_JOBS + 3; k++) send_cmd(FUNC_LOAD, random_job(FIELDS_MID));
    repeat (8) send_cmd(FUNC_NEXT, random_job(FIELDS_FULL));
    send_cmd(FUNC_LOAD, random_job(FIELDS_NARROW));
    // sender waits out every result before going on
    wait_drained();
    gaps_on = 1'b1;
  endtask

  // random load and run sequences with some noise between them
  task automatic test_random();
    int base;
    int njobs;
    int style;
    int runs;
    base = items_sent;
    set_policy(POL_FCFS);
    while (items_sent - base < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) set_policy(2'($urandom_range(0, 3)));
      gaps_on = ($urandom_range(0, 3) != 0);
      style   = $urandom_range(0, 2);
      njobs   = ($urandom_range(0, 11) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 10);
      if ($urandom_range(0, 4) != 0) send_cmd(FUNC_CLEAR, random_job(FIELDS_FULL));
      for (int k = 0; k < njobs; k++) begin
        send_cmd(FUNC_LOAD, random_job(style));
        if ($urandom_range(0, 5) == 0) send_cmd(FUNC_NEXT, random_job(FIELDS_FULL));
      end
      runs = jobs_loaded - jobs_run;
      runs = ($urandom_range(0, 3) == 0) ? runs / 2 : runs + $urandom_range(0, 1);
      repeat (runs) send_cmd(FUNC_NEXT, random_job(FIELDS_FULL));
      if ($urandom_range(0, 3) == 0) send_cmd(2'($urandom_range(0, 3)), random_job(style));
    end
  endtask

  // stimulus
  initial begin
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_tie_rules();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && outcome_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // receiver stalls on its own pattern, with a hold-off on request
  initial begin
    rx_pattern_e pattern;
    int          span;
    int          period;
    int          hold;
    m_axis_tready <= 1'b0;
    forever begin
      pattern = rx_pattern_e'($urandom_range(0, 3));
      span    = $urandom_range(32, 200);
      period  = $urandom_range(2, 9);
      for (int n = 0; n < span; n++) begin
        @(posedge clk_i);
        if (holdoff_len != 0) begin
          hold        = holdoff_len;
          holdoff_len = 0;
          m_axis_tready <= 1'b0;
          repeat (hold) @(posedge clk_i);
        end
        case (pattern)
          RX_COIN:     m_axis_tready <= ($urandom_range(0, 1) != 0);
          RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 7) != 0);
          RX_PERIODIC: m_axis_tready <= ((n % period) != 0);
          default:     m_axis_tready <= 1'b1;
        endcase
      end
    end
  end

  task automatic cmp_field(input string fld, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, want, got);
      fail_count++;
    end
  endtask

  // compare every result transaction with the oldest expectation
  always @(posedge clk_i) begin : result_check
    outcome_t want;
    res_t     got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(res_t)-1:0];
      if (outcome_q.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual status %0d",
                 $time, m_axis_tuser);
        fail_count++;
      end else begin
        want = outcome_q.pop_front();
        cmp_field("status", want.status, m_axis_tuser);
        cmp_field("run_id", want.res.run_id, got.run_id);
        cmp_field("start_time", want.res.start_time, got.start_time);
        cmp_field("end_time", want.res.end_time, got.end_time);
        cmp_field("has_slice", want.res.has_slice, got.has_slice);
        cmp_field("turnaround", want.res.turnaround, got.turnaround);
        cmp_field("waiting", want.res.waiting, got.waiting);
        cmp_field("busy_total", want.res.busy_total, got.busy_total);
        cmp_field("all_done", want.res.all_done, got.all_done);
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    int idle_run;
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
          || (cfg_valid_i && cfg_ready_o)) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
    end
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

endmodule
